@@ design/prm_pkg.sv @@
package prm_pkg;

    localparam int MAX_DIM        = 4096;
    localparam int COEF_FRAC_BITS = 14;

    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int OFS_W      = 13;
    localparam int COEF_W     = 16;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);
    localparam logic signed [COEF_W-1:0] RST_COS = COEF_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_COS_COEF     = 3'd1,
        CFG_SIN_COEF     = 3'd2,
        CFG_TAN_HALF     = 3'd3,
        CFG_FRAME_WIDTH  = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        MODE_DIRECT = 1'b0,
        MODE_SHEAR  = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic signed [COEF_W-1:0]  cos_coef;
        logic signed [COEF_W-1:0]  sin_coef;
        logic signed [COEF_W-1:0]  tan_half_coef;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
        logic [COORD_W-1:0]        cx;
        logic [COORD_W-1:0]        cy;
    } t_cfg;

    typedef struct packed {
        t_mode                    mode;
        logic signed [OFS_W-1:0]  xo;
        logic signed [OFS_W-1:0]  yo;
        logic [PIX_W-1:0]         pixel;
    } t_item;

endpackage

@@ design/pixel_rotation_mapper.sv @@
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+----------------------------------
// input    | in        | i_valid / o_stall            | i_src_x, i_src_y, i_pixel_value
// output   | out       | o_valid / i_stall            | o_dest_x, o_dest_y, o_pixel_out
// config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One pixel per cycle sustained while not stalled; an input transfer reaches the result
// through the front register, queue, six arithmetic stages and output register.
// Shear mode sets the depth: its three dependent multiplies each take a stage.
// Pixels that land outside the frame are dropped at the output register.
// Reset is synchronous; it empties the queue and pipeline and loads register defaults.
// An output stall holds the arithmetic pipeline; the four-entry queue absorbs the front.
module pixel_rotation_mapper #(
    parameter int COEF_FRAC_BITS = prm_pkg::COEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [prm_pkg::COORD_W-1:0]     i_src_x,
    input  logic [prm_pkg::COORD_W-1:0]     i_src_y,
    input  logic [prm_pkg::PIX_W-1:0]       i_pixel_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [prm_pkg::COORD_W-1:0]     o_dest_x,
    output logic [prm_pkg::COORD_W-1:0]     o_dest_y,
    output logic [prm_pkg::PIX_W-1:0]       o_pixel_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    prm_pkg::t_mode                          r_mode;
    logic signed [prm_pkg::COEF_W-1:0]       r_cos_coef;
    logic signed [prm_pkg::COEF_W-1:0]       r_sin_coef;
    logic signed [prm_pkg::COEF_W-1:0]       r_tan_half_coef;
    logic [prm_pkg::DIM_W-1:0]               r_frame_width;
    logic [prm_pkg::DIM_W-1:0]               r_frame_height;

    prm_pkg::t_cfg   cfg;
    prm_pkg::t_item  q_in_item;
    prm_pkg::t_item  q_out_item;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    logic            cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= prm_pkg::MODE_DIRECT;
            r_cos_coef      <= prm_pkg::RST_COS;
            r_sin_coef      <= '0;
            r_tan_half_coef <= '0;
            r_frame_width   <= prm_pkg::RST_WIDTH;
            r_frame_height  <= prm_pkg::RST_HEIGHT;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                prm_pkg::CFG_MODE:         r_mode <= prm_pkg::t_mode'(i_cfg_data[0]);
                prm_pkg::CFG_COS_COEF:     r_cos_coef <= $signed(i_cfg_data);
                prm_pkg::CFG_SIN_COEF:     r_sin_coef <= $signed(i_cfg_data);
                prm_pkg::CFG_TAN_HALF:     r_tan_half_coef <= $signed(i_cfg_data);
                prm_pkg::CFG_FRAME_WIDTH:  r_frame_width <= i_cfg_data[prm_pkg::DIM_W-1:0];
                prm_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[prm_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.mode          = r_mode;
        cfg.cos_coef      = r_cos_coef;
        cfg.sin_coef      = r_sin_coef;
        cfg.tan_half_coef = r_tan_half_coef;
        cfg.w = (32'(r_frame_width) > 32'(prm_pkg::MAX_DIM))
                ? prm_pkg::DIM_W'(prm_pkg::MAX_DIM) : r_frame_width;
        cfg.h = (32'(r_frame_height) > 32'(prm_pkg::MAX_DIM))
                ? prm_pkg::DIM_W'(prm_pkg::MAX_DIM) : r_frame_height;
        cfg.cx = cfg.w[prm_pkg::DIM_W-1:1];
        cfg.cy = cfg.h[prm_pkg::DIM_W-1:1];
    end

    prm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_pixel_value (i_pixel_value),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (q_in_item)
    );

    prm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    prm_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_item    (q_out_item),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_dest_x    (o_dest_x),
        .o_dest_y    (o_dest_y),
        .o_pixel_out (o_pixel_out)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_dest_x_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_dest_x} < cfg.w))
        else $error("result column outside frame");

    a_dest_y_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_dest_y} < cfg.h))
        else $error("result row outside frame");

endmodule

@@ design/prm_front.sv @@
module prm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prm_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [prm_pkg::COORD_W-1:0]  i_src_x,
    input  logic [prm_pkg::COORD_W-1:0]  i_src_y,
    input  logic [prm_pkg::PIX_W-1:0]    i_pixel_value,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output prm_pkg::t_item               o_q_item
);

    logic           r_valid;
    prm_pkg::t_item r_item;
    logic           n_valid;
    prm_pkg::t_item n_item;
    logic           load;

    assign o_q_push = r_valid && !i_q_full;
    assign o_stall  = r_valid && i_q_full;
    assign o_q_item = r_item;
    assign load     = !r_valid || o_q_push;

    always_comb begin
        n_item.mode  = i_cfg.mode;
        n_item.xo    = $signed({1'b0, i_src_x}) - $signed({1'b0, i_cfg.cx});
        n_item.yo    = $signed({1'b0, i_src_y}) - $signed({1'b0, i_cfg.cy});
        n_item.pixel = i_pixel_value;
        n_valid      = load ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ design/prm_queue.sv @@
module prm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  prm_pkg::t_item  i_item,
    input  logic            i_pop,
    output prm_pkg::t_item  o_item,
    output logic            o_full,
    output logic            o_empty
);

    prm_pkg::t_item                  r_buf [prm_pkg::QDEPTH];
    logic [prm_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [prm_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [prm_pkg::QCNT_W-1:0]      r_count;
    logic [prm_pkg::QCNT_W-1:0]      n_count;

    assign o_full  = (r_count == prm_pkg::QCNT_W'(prm_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_buf[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ design/prm_back.sv @@
module prm_back #(
    parameter int COEF_FRAC_BITS = prm_pkg::COEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prm_pkg::t_cfg                i_cfg,
    input  prm_pkg::t_item               i_q_item,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [prm_pkg::COORD_W-1:0]  o_dest_x,
    output logic [prm_pkg::COORD_W-1:0]  o_dest_y,
    output logic [prm_pkg::PIX_W-1:0]    o_pixel_out
);

    localparam int F    = COEF_FRAC_BITS;
    localparam int OW   = prm_pkg::OFS_W;
    localparam int CW   = prm_pkg::COEF_W;
    localparam int PW   = OW + CW;
    localparam int CTRW = prm_pkg::COORD_W + 1 + F;
    localparam int DAW  = ((PW + 1 > CTRW) ? PW + 1 : CTRW) + 2;
    localparam int DRW  = DAW - F;
    localparam int S1W  = ((CTRW > PW) ? CTRW : PW) + 2;
    localparam int U1W  = S1W - F;
    localparam int QW   = U1W + CW;
    localparam int S2W  = ((QW > OW + F) ? QW : OW + F) + 2;
    localparam int VW   = S2W - F;
    localparam int RW   = VW + CW;
    localparam int S3W  = ((U1W + F > RW) ? U1W + F : RW) + 2;
    localparam int U2W  = S3W - F;
    localparam int FW0  = (DRW > U2W) ? DRW : U2W;
    localparam int FW   = ((FW0 > VW) ? FW0 : VW) + 1;

    localparam logic signed [DAW-1:0] HALF_D = DAW'(longint'(1) <<< (F - 1));
    localparam logic signed [S1W-1:0] HALF_1 = S1W'(longint'(1) <<< (F - 1));
    localparam logic signed [S2W-1:0] HALF_2 = S2W'(longint'(1) <<< (F - 1));
    localparam logic signed [S3W-1:0] HALF_3 = S3W'(longint'(1) <<< (F - 1));

    logic en;
    logic [6:1] r_vld;

    prm_pkg::t_mode             r1_mode, r2_mode, r3_mode, r4_mode, r5_mode;
    logic [prm_pkg::PIX_W-1:0]  r1_pix, r2_pix, r3_pix, r4_pix, r5_pix, r6_pix;
    logic signed [OW-1:0]       r1_xo, r1_yo, r2_yo, r3_yo;
    logic signed [PW-1:0]       r1_p0, r1_p1, r1_p2, r1_p3;
    logic signed [DRW-1:0]      r2_dx, r2_dy, r3_dx, r3_dy, r4_dx, r4_dy, r5_dx, r5_dy;
    logic signed [U1W-1:0]      r2_u1, r3_u1, r4_u1, r5_u1;
    logic signed [QW-1:0]       r3_q;
    logic signed [VW-1:0]       r4_v, r5_v;
    logic signed [RW-1:0]       r5_r;
    logic signed [FW-1:0]       r6_fx, r6_fy;

    logic                       r_out_valid;

    logic                       shear1;
    logic signed [OW-1:0]       mul_a;
    logic signed [CW-1:0]       mul_b;
    logic signed [OW-1:0]       cx_s, cy_s;
    logic signed [DAW-1:0]      sum_dx, sum_dy, rnd_dx, rnd_dy;
    logic signed [S1W-1:0]      sum_1, rnd_1;
    logic signed [S2W-1:0]      sum_2, rnd_2;
    logic signed [S3W-1:0]      sum_3, rnd_3;
    logic signed [FW-1:0]       n_fx, n_fy;
    logic                       in_frame;

    assign en      = !r_out_valid || !i_stall;
    assign o_q_pop = en && !i_q_empty;
    assign o_valid = r_out_valid;

    assign cx_s = $signed({1'b0, i_cfg.cx});
    assign cy_s = $signed({1'b0, i_cfg.cy});

    always_comb begin
        shear1 = (i_q_item.mode == prm_pkg::MODE_SHEAR);
        mul_a  = shear1 ? i_q_item.yo : i_q_item.xo;
        mul_b  = shear1 ? i_cfg.tan_half_coef : i_cfg.cos_coef;
    end

    always_comb begin
        sum_dx = DAW'(r1_p0) + DAW'(r1_p1) + (DAW'(cx_s) <<< F);
        sum_dy = DAW'(r1_p2) - DAW'(r1_p3) + (DAW'(cy_s) <<< F);
        rnd_dx = sum_dx + HALF_D - $signed(DAW'(sum_dx[DAW-1]));
        rnd_dy = sum_dy + HALF_D - $signed(DAW'(sum_dy[DAW-1]));
        sum_1  = (S1W'(r1_xo) <<< F) - S1W'(r1_p0);
        rnd_1  = sum_1 + HALF_1 - $signed(S1W'(sum_1[S1W-1]));
        sum_2  = S2W'(r3_q) + (S2W'(r3_yo) <<< F);
        rnd_2  = sum_2 + HALF_2 - $signed(S2W'(sum_2[S2W-1]));
        sum_3  = (S3W'(r5_u1) <<< F) - S3W'(r5_r);
        rnd_3  = sum_3 + HALF_3 - $signed(S3W'(sum_3[S3W-1]));
        if (r5_mode == prm_pkg::MODE_SHEAR) begin
            n_fx = FW'($signed(rnd_3[S3W-1:F])) + FW'(cx_s);
            n_fy = FW'(r5_v) + FW'(cy_s);
        end else begin
            n_fx = FW'(r5_dx);
            n_fy = FW'(r5_dy);
        end
        in_frame = !r6_fx[FW-1] && !r6_fy[FW-1]
                   && (r6_fx < $signed(FW'(i_cfg.w)))
                   && (r6_fy < $signed(FW'(i_cfg.h)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[5:1], !i_q_empty};
            r_out_valid <= r_vld[6] && in_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mode <= i_q_item.mode;
            r1_pix  <= i_q_item.pixel;
            r1_xo   <= i_q_item.xo;
            r1_yo   <= i_q_item.yo;
            r1_p0   <= PW'(mul_a) * PW'(mul_b);
            r1_p1   <= PW'(i_q_item.yo) * PW'(i_cfg.sin_coef);
            r1_p2   <= PW'(i_q_item.yo) * PW'(i_cfg.cos_coef);
            r1_p3   <= PW'(i_q_item.xo) * PW'(i_cfg.sin_coef);

            r2_mode <= r1_mode;
            r2_pix  <= r1_pix;
            r2_yo   <= r1_yo;
            r2_dx   <= rnd_dx[DAW-1:F];
            r2_dy   <= rnd_dy[DAW-1:F];
            r2_u1   <= rnd_1[S1W-1:F];

            r3_mode <= r2_mode;
            r3_pix  <= r2_pix;
            r3_yo   <= r2_yo;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_u1   <= r2_u1;
            r3_q    <= QW'(r2_u1) * QW'(i_cfg.sin_coef);

            r4_mode <= r3_mode;
            r4_pix  <= r3_pix;
            r4_dx   <= r3_dx;
            r4_dy   <= r3_dy;
            r4_u1   <= r3_u1;
            r4_v    <= rnd_2[S2W-1:F];

            r5_mode <= r4_mode;
            r5_pix  <= r4_pix;
            r5_dx   <= r4_dx;
            r5_dy   <= r4_dy;
            r5_u1   <= r4_u1;
            r5_v    <= r4_v;
            r5_r    <= RW'(r4_v) * RW'(i_cfg.tan_half_coef);

            r6_pix  <= r5_pix;
            r6_fx   <= n_fx;
            r6_fy   <= n_fy;

            o_dest_x    <= r6_fx[prm_pkg::COORD_W-1:0];
            o_dest_y    <= r6_fy[prm_pkg::COORD_W-1:0];
            o_pixel_out <= r6_pix;
        end
    end

endmodule
